@@ hw/rtl/fbfl_pkg.sv @@
// Shared types and codes for the fixed block free list unit.
package fbfl_pkg;

  localparam int unsigned CountW = 11;
  localparam int unsigned IndexW = 10;
  localparam int unsigned AddrW  = 48;
  localparam int unsigned SizeW  = 17;
  localparam int unsigned LinkW  = 11;

  // Actions carried in the input tuser field
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;
  localparam logic [1:0] ACT_RANGE = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  // Register indexes, paddr[4:3]
  localparam logic [1:0] REG_COUNT = 2'd0;
  localparam logic [1:0] REG_BASE  = 2'd1;
  localparam logic [1:0] REG_SIZE  = 2'd2;

  localparam logic [CountW-1:0] COUNT_RST = 11'd1024;
  localparam logic [AddrW-1:0]  BASE_RST  = 48'd0;
  localparam logic [SizeW-1:0]  SIZE_RST  = 17'd4096;
  localparam logic [LinkW-1:0]  HEAD_RST  = 11'd1024;

  typedef struct packed {
    logic [CountW-1:0] blk_count;
    logic [AddrW-1:0]  base_address;
    logic [SizeW-1:0]  blk_size;
  } cfg_t;

  typedef struct packed {
    logic             wr;
    logic             rd;
    logic [LinkW-1:0] idx;
    logic [LinkW-1:0] wdata;
  } link_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [IndexW-1:0] result_index;
    logic [AddrW-1:0]  result_address;
  } res_t;

endpackage

@@ hw/rtl/fbfl_cfg_regs.sv @@
// APB register file: object count, base address, object size.
module fbfl_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [63:0]   pwdata,
  output logic [63:0]   prdata,
  output logic          pready,
  output fbfl_pkg::cfg_t cfg_o
);
  import fbfl_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[4:3])
        REG_COUNT: cfg_d.blk_count    = pwdata[CountW-1:0];
        REG_BASE:  cfg_d.base_address = pwdata[AddrW-1:0];
        REG_SIZE:  cfg_d.blk_size     = pwdata[SizeW-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.blk_count    <= COUNT_RST;
      cfg_q.base_address <= BASE_RST;
      cfg_q.blk_size     <= SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_COUNT: prdata = {53'd0, cfg_q.blk_count};
      REG_BASE:  prdata = {16'd0, cfg_q.base_address};
      REG_SIZE:  prdata = {47'd0, cfg_q.blk_size};
      default:   prdata = 64'd0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ hw/rtl/fbfl_link_mem.sv @@
// Next-link memory: one write or one read per cycle, registered read data.
module fbfl_link_mem #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                        clk_i,
  input  fbfl_pkg::link_req_t         req_i,
  output logic [fbfl_pkg::LinkW-1:0]  rdata_o
);
  import fbfl_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [LinkW-1:0] mem [DEPTH];
  logic [LinkW-1:0] rdata_q;
  logic [AW-1:0]    addr;

  assign addr = AW'(req_i.idx);

  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      mem[addr] <= req_i.wdata;
    end
    if (req_i.rd) begin
      rdata_q <= mem[addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/fbfl_addr_calc.sv @@
// Block address: registered index * size, then base added.
module fbfl_addr_calc (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic [fbfl_pkg::LinkW-1:0]  idx_i,
  input  logic [fbfl_pkg::SizeW-1:0]  size_i,
  input  logic [fbfl_pkg::AddrW-1:0]  base_i,
  output logic [fbfl_pkg::AddrW-1:0]  addr_o
);
  import fbfl_pkg::*;

  localparam int unsigned ProdW = LinkW + SizeW;

  logic [ProdW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      prod_q <= ProdW'(idx_i) * ProdW'(size_i);
    end
  end

  // wraps to 48 bits
  assign addr_o = base_i + AddrW'(prod_q);

endmodule

@@ hw/rtl/fbfl_ctrl.sv @@
// Sequencer: init walk, pop, push and range push over the link memory.
module fbfl_ctrl #(
  parameter int unsigned MAX_OBJECTS = 1024
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fbfl_pkg::cfg_t               cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   action_i,
  input  logic [fbfl_pkg::IndexW-1:0]  block_index_i,
  input  logic [fbfl_pkg::CountW-1:0]  run_length_i,
  output fbfl_pkg::link_req_t          link_req_o,
  input  logic [fbfl_pkg::LinkW-1:0]   link_rdata_i,
  output logic                         addr_start_o,
  output logic [fbfl_pkg::LinkW-1:0]   addr_idx_o,
  input  logic [fbfl_pkg::AddrW-1:0]   addr_i,
  output logic                         res_valid_o,
  input  logic                         res_ready_i,
  output fbfl_pkg::res_t               res_o
);
  import fbfl_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_RANGE = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  localparam logic [16:0] MaxObj = 17'(MAX_OBJECTS);

  logic [2:0]        state_q, state_d;
  logic [LinkW-1:0]  head_q, head_d;
  logic [CountW-1:0] walk_q, walk_d;     // init index or remaining range count
  logic [IndexW-1:0] bidx_q, bidx_d;
  logic              err_q, err_d;
  res_t              res_q, res_d;

  logic [CountW-1:0] pool_n;
  logic [LinkW:0]    range_idx;          // one bit wider: index + run can pass 2047
  logic              accept;

  assign pool_n = ({6'd0, cfg_i.blk_count} > MaxObj) ? CountW'(MaxObj)
                                                     : cfg_i.blk_count;
  assign range_idx = {2'b00, bidx_q} + {1'b0, walk_q} - 12'd1;
  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    walk_d       = walk_q;
    bidx_d       = bidx_q;
    err_d        = err_q;
    res_d        = res_q;
    link_req_o   = '0;
    addr_start_o = 1'b0;
    addr_idx_o   = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.status         = ST_OK;
          res_d.result_index   = '0;
          res_d.result_address = '0;
          bidx_d               = block_index_i;
          state_d              = S_RESP;
          case (action_i)
            ACT_INIT: begin
              walk_d = '0;
              if (pool_n == '0) begin
                head_d = '0;
              end else begin
                state_d = S_INIT;
              end
            end
            ACT_ALLOC: begin
              if (head_q >= pool_n) begin
                res_d.status = ST_EMPTY;
              end else begin
                link_req_o.rd      = 1'b1;
                link_req_o.idx     = head_q;
                addr_start_o       = 1'b1;
                res_d.result_index = head_q[IndexW-1:0];
                state_d            = S_ALLOC;
              end
            end
            ACT_FREE: begin
              res_d.result_index = block_index_i;
              if ({1'b0, block_index_i} < pool_n) begin
                link_req_o.wr    = 1'b1;
                link_req_o.idx   = {1'b0, block_index_i};
                link_req_o.wdata = head_q;
                head_d           = {1'b0, block_index_i};
              end else begin
                res_d.status = ST_RANGE;
              end
            end
            default: begin
              // free range: push from highest index down
              res_d.result_index = block_index_i;
              err_d              = 1'b0;
              walk_d             = run_length_i;
              if (run_length_i != '0) begin
                state_d = S_RANGE;
              end
            end
          endcase
        end
      end
      S_INIT: begin
        link_req_o.wr    = 1'b1;
        link_req_o.idx   = walk_q;
        link_req_o.wdata = walk_q + 11'd1;
        walk_d           = walk_q + 11'd1;
        if (walk_q + 11'd1 == pool_n) begin
          head_d  = '0;
          state_d = S_RESP;
        end
      end
      S_ALLOC: begin
        head_d               = link_rdata_i;
        res_d.result_address = addr_i;
        state_d              = S_RESP;
      end
      S_RANGE: begin
        if (range_idx < {1'b0, pool_n}) begin
          link_req_o.wr    = 1'b1;
          link_req_o.idx   = range_idx[LinkW-1:0];
          link_req_o.wdata = head_q;
          head_d           = range_idx[LinkW-1:0];
        end else begin
          err_d = 1'b1;
        end
        walk_d = walk_q - 11'd1;
        if (walk_q == 11'd1) begin
          res_d.status = (err_d) ? ST_RANGE : ST_OK;
          state_d      = S_RESP;
        end
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= HEAD_RST;
      walk_q  <= '0;
      err_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      walk_q  <= walk_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q <= bidx_d;
    res_q  <= res_d;
  end

  assign res_valid_o = (state_q == S_RESP);
  assign res_o       = res_q;

endmodule

@@ hw/rtl/fixed_block_free_list_unit.sv @@
// Top level of the fixed block free list: stream ports, APB registers, result register.
//
// A pool of equal-sized blocks kept as a LIFO free list: a next-link memory of
// MAX_OBJECTS entries holds the chain, a head register the first free block.
// Each item on the input stream carries an action in tuser (init, allocate,
// free one, free range) and returns exactly one result item carrying a status
// in tuser and the block index and byte address in tdata. One item is worked
// on at a time, paced by the single port of the link memory, one access per
// cycle. With the output register free, result valid rises in the cycle after
// the accepting edge for free one, allocate on an empty pool, init of an empty
// pool and free range of length 0. Allocate first reads the head's link from
// memory, then takes the new head; init makes one link write per block and
// free range one push or skip per block before the result. A new item is taken
// as soon as the previous result has moved to the output register, even if the
// sink has not yet taken it; while that register is still held, the finished
// result waits and the input stays blocked. The pool size is the smaller of the
// block count register and MAX_OBJECTS; the link memory is not cleared at
// reset, so run init before the first allocate. Write the registers only while
// the unit is idle.
module fixed_block_free_list_unit #(
  parameter int unsigned MAX_OBJECTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [23:0] s_tdata_i,   // [9:0] block_index, [20:10] run_length
  input  logic [1:0]  s_tuser_i,   // [1:0] action
  // result stream
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [63:0] m_tdata_o,   // [9:0] result_index, [57:10] result_address
  output logic [1:0]  m_tuser_o,   // [1:0] status
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);
  import fbfl_pkg::*;

  cfg_t             cfg;
  link_req_t        link_req;
  logic [LinkW-1:0] link_rdata;
  logic             addr_start;
  logic [LinkW-1:0] addr_idx;
  logic [AddrW-1:0] blk_addr;
  logic             res_valid;
  logic             res_ready;
  res_t             res;

  logic out_valid_q, out_valid_d;
  res_t out_q;

  fbfl_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fbfl_link_mem #(
    .DEPTH (MAX_OBJECTS)
  ) u_mem (
    .clk_i   (clk_i),
    .req_i   (link_req),
    .rdata_o (link_rdata)
  );

  fbfl_addr_calc u_addr (
    .clk_i   (clk_i),
    .start_i (addr_start),
    .idx_i   (addr_idx),
    .size_i  (cfg.blk_size),
    .base_i  (cfg.base_address),
    .addr_o  (blk_addr)
  );

  fbfl_ctrl #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .action_i      (s_tuser_i),
    .block_index_i (s_tdata_i[9:0]),
    .run_length_i  (s_tdata_i[20:10]),
    .link_req_o    (link_req),
    .link_rdata_i  (link_rdata),
    .addr_start_o  (addr_start),
    .addr_idx_o    (addr_idx),
    .addr_i        (blk_addr),
    .res_valid_o   (res_valid),
    .res_ready_i   (res_ready),
    .res_o         (res)
  );

  // output register: loads when empty or being drained this cycle
  assign res_ready = !out_valid_q || m_tready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tuser_o  = out_q.status;
  assign m_tdata_o  = {6'd0, out_q.result_address, out_q.result_index};

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps
// Testbench for fixed_block_free_list_unit: directed and random free-list traffic checked against an inline model.
module tb;
  import fbfl_pkg::*;

  // Must match the DUT parameter below; the model clamps the pool to it.
  localparam int unsigned PoolMax = 1024;

  // ---------------------------------------------------------------------------
  // Clock, reset and DUT ports. Every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [23:0] s_tdata_i  = '0;   // [9:0] block_index, [20:10] run_length
  logic [1:0]  s_tuser_i  = '0;   // [1:0] action
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [63:0] m_tdata_o;         // [9:0] result_index, [57:10] result_address
  logic [1:0]  m_tuser_o;         // [1:0] status
  logic        psel       = 1'b0;
  logic        penable    = 1'b0;
  logic        pwrite     = 1'b0;
  logic [4:0]  paddr      = '0;
  logic [63:0] pwdata     = '0;
  logic [63:0] prdata;
  logic        pready;

  always #10 clk_i = ~clk_i;

  fixed_block_free_list_unit #(
    .MAX_OBJECTS(PoolMax)
  ) dut (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_tvalid_i(s_tvalid_i),
    .s_tready_o(s_tready_o),
    .s_tdata_i (s_tdata_i),
    .s_tuser_i (s_tuser_i),
    .m_tvalid_o(m_tvalid_o),
    .m_tready_i(m_tready_i),
    .m_tdata_o (m_tdata_o),
    .m_tuser_o (m_tuser_o),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // ---------------------------------------------------------------------------
  // Free-list model state: a shadow of the registers, the head and the link
  // memory. link_valid tracks which link entries the DUT has ever written;
  // the link RAM is not cleared at reset, so an allocate must never pop a
  // head whose link entry is still unwritten.
  // ---------------------------------------------------------------------------
  logic [CountW-1:0] cfg_count = COUNT_RST;
  logic [AddrW-1:0]  cfg_base  = BASE_RST;
  logic [SizeW-1:0]  cfg_size  = SIZE_RST;
  logic [LinkW-1:0]  list_head = HEAD_RST;
  logic [LinkW-1:0]  link_mem   [PoolMax];
  bit                link_valid [PoolMax];

  res_t        outcome_q[$];    // results still owed by the DUT, oldest first
  int unsigned held_blocks[$];  // blocks handed out and not yet returned
  int          error_count = 0;
  int unsigned gap_pct     = 0; // chance per cycle the sender holds off
  int unsigned stall_pct   = 0; // chance per cycle the sink drops tready

  // Effective pool size: block count clamped to the link memory depth.
  function automatic int unsigned pool_blocks();
    return (int'(cfg_count) > PoolMax) ? PoolMax : int'(cfg_count);
  endfunction

  // Push one block on the list; out-of-range indices are refused.
  function automatic bit push_block(input int unsigned blk);
    if (blk >= pool_blocks()) return 1'b0;
    link_mem[blk]   = list_head;
    link_valid[blk] = 1'b1;
    list_head       = LinkW'(blk);
    return 1'b1;
  endfunction

  // An allocate is safe unless it would follow an unwritten link.
  function automatic bit alloc_is_defined();
    return (list_head >= pool_blocks()) || link_valid[list_head];
  endfunction

  // Apply one item to the model and return the result it must produce.
  function automatic res_t free_list_outcome(input logic [1:0] act, input logic [9:0] idx,
                                             input logic [10:0] run);
    res_t        res;
    int unsigned n;
    int unsigned k;
    res = '0;
    n   = pool_blocks();
    case (act)
      ACT_INIT: begin
        for (k = 0; k < n; k++) begin
          link_mem[k]   = LinkW'(k + 1);
          link_valid[k] = 1'b1;
        end
        list_head = '0;
      end
      ACT_ALLOC: begin
        if (list_head >= n) begin
          res.status = ST_EMPTY;
        end else begin
          res.result_index   = list_head[IndexW-1:0];
          // 48-bit context: the address wraps like the hardware adder
          res.result_address = cfg_base + AddrW'(list_head) * AddrW'(cfg_size);
          list_head          = link_mem[list_head];
        end
      end
      ACT_FREE: begin
        res.result_index = idx;
        if (!push_block(idx)) res.status = ST_RANGE;
      end
      default: begin
        // range free pushes highest index first, each index checked alone
        res.result_index = idx;
        for (k = run; k > 0; k--) begin
          if (!push_block(int'(idx) + k - 1)) res.status = ST_RANGE;
        end
      end
    endcase
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream driver. In send_item, s_tvalid_i is only lowered during a hold-off, so a
  // back-to-back item never sees a low and a high in the same time step.
  // The model runs at the accepting edge, which is the DUT's order too.
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [1:0] act, input logic [9:0] idx,
                           input logic [10:0] run, output res_t outcome);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {3'b000, run, idx};
    s_tuser_i  <= act;
    do @(posedge clk_i); while (!s_tready_o);
    outcome = free_list_outcome(act, idx, run);
    outcome_q.push_back(outcome);
  endtask

  // Drop valid and wait until every owed result has been taken; the DUT
  // holds no further work once its last result has left.
  task automatic wait_idle();
    s_tvalid_i <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
  endtask

  // One APB write: setup then access; the register takes the value at the
  // edge with psel, penable and pready high. The bus is left selected so a
  // following write can go straight into its setup phase.
  task automatic write_reg(input logic [1:0] reg_idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
  endtask

  task automatic write_config(input logic [CountW-1:0] count, input logic [AddrW-1:0] base,
                              input logic [SizeW-1:0] size);
    wait_idle();
    write_reg(REG_COUNT, 64'(count));
    write_reg(REG_BASE, 64'(base));
    write_reg(REG_SIZE, 64'(size));
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    cfg_count = count;
    cfg_base  = base;
    cfg_size  = size;
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: compare each accepted result field by field with the
  // oldest owed one. The sink's tready is re-rolled every cycle.
  // ---------------------------------------------------------------------------
  task automatic check_outcome(input logic [1:0] status, input logic [63:0] data);
    res_t want;
    if (outcome_q.size() == 0) begin
      $error("result with none owed: status %0d index %0d", status, data[9:0]);
      error_count++;
      return;
    end
    want = outcome_q.pop_front();
    if (status !== want.status) begin
      $error("status: expected %0d, got %0d", want.status, status);
      error_count++;
    end
    if (data[9:0] !== want.result_index) begin
      $error("result_index: expected %0d, got %0d", want.result_index, data[9:0]);
      error_count++;
    end
    if (data[57:10] !== want.result_address) begin
      $error("result_address: expected 0x%012h, got 0x%012h", want.result_address,
             data[57:10]);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready_i <= 1'b0;
    end else begin
      if (m_tvalid_o && m_tready_i) check_outcome(m_tuser_o, m_tdata_o);
      m_tready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------------

  // Straight out of reset the head is the empty marker: allocate reports an
  // empty pool. A single free makes one block available, then empty again.
  task automatic test_empty_after_reset();
    res_t r;
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_FREE, 10'd5, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
  endtask

  // Small pool: init chains blocks, allocate drains it down to empty, and
  // freeing the ceiling or beyond is refused.
  task automatic test_init_alloc_free();
    res_t r;
    write_config(11'd4, 48'h0000_1000_0000, 17'd256);
    send_item(ACT_INIT, 10'd0, 11'd0, r);
    repeat (5) send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_FREE, 10'd4, 11'd0, r);       // ceiling itself
    send_item(ACT_FREE, 10'd1023, 11'd0, r);    // far out of range
    send_item(ACT_FREE, 10'd3, 11'd0, r);
  endtask

  // Range free: empty run, a run straddling the ceiling, a run fully inside.
  task automatic test_range_free();
    res_t r;
    send_item(ACT_RANGE, 10'd0, 11'd0, r);
    send_item(ACT_RANGE, 10'd2, 11'd4, r);      // 4 and 5 skipped
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_RANGE, 10'd0, 11'd4, r);
  endtask

  // Register extremes: a zero-block pool, then a count above the memory
  // depth with the largest base and size so the address wraps.
  task automatic test_config_extremes();
    res_t r;
    write_config(11'd0, 48'd0, 17'd1);
    send_item(ACT_INIT, 10'd0, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_FREE, 10'd0, 11'd0, r);
    write_config(11'h7FF, 48'hFFFF_FFFF_FFFF, 17'h1FFFF);
    send_item(ACT_INIT, 10'd0, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
    send_item(ACT_FREE, 10'd1023, 11'd0, r);
    send_item(ACT_ALLOC, 10'd0, 11'd0, r);
  endtask

  // ---------------------------------------------------------------------------
  // Random traffic under one register setting and one idling mix. Mostly
  // allocate/free pairs on a freshly chained pool so the list goes deep,
  // with range frees, stray frees, ceiling probes and re-inits mixed in.
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input logic [CountW-1:0] count,
                                     input logic [AddrW-1:0] base,
                                     input logic [SizeW-1:0] size,
                                     input int unsigned src_gap, input int unsigned snk_stall,
                                     input int unsigned num_items);
    res_t        r;
    logic [1:0]  act;
    logic [9:0]  idx;
    logic [10:0] run;
    int unsigned roll;
    int unsigned n;
    int unsigned pick;
    write_config(count, base, size);
    gap_pct   = src_gap;
    stall_pct = snk_stall;
    send_item(ACT_INIT, 10'd0, 11'd0, r);
    held_blocks.delete();
    for (int i = 0; i < num_items; i++) begin
      roll = $urandom_range(99);
      n    = pool_blocks();
      idx  = '0;
      run  = '0;
      if (roll < 4) begin
        act = ACT_INIT;
      end else if (roll < 48) begin
        act = ACT_ALLOC;
      end else if (roll < 76 && held_blocks.size() != 0) begin
        act  = ACT_FREE;
        pick = $urandom_range(held_blocks.size() - 1);
        idx  = 10'(held_blocks[pick]);
        held_blocks.delete(pick);
      end else if (roll < 82) begin
        act = ACT_FREE;
        if ($urandom_range(1)) idx = 10'($urandom_range(1023));
        else idx = (n == 0) ? 10'd0 : 10'(n - 1 + $urandom_range(1));   // just below or at the ceiling
      end else begin
        act  = ACT_RANGE;
        idx  = $urandom_range(1) ? 10'($urandom_range(1023))
                                 : 10'($urandom_range((n == 0) ? 0 : n - 1));
        roll = $urandom_range(99);
        if (roll < 85) run = 11'($urandom_range(6));
        else if (roll < 97) run = 11'($urandom_range(64));
        else run = 11'($urandom_range(2047));
      end
      // never let an allocate follow a link entry that was never written
      if (act == ACT_ALLOC && !alloc_is_defined()) act = ACT_INIT;
      send_item(act, idx, run, r);
      if (act == ACT_INIT) held_blocks.delete();
      if (act == ACT_ALLOC && r.status == ST_OK) held_blocks.push_back(r.result_index);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_after_reset();
    test_init_alloc_free();
    test_range_free();
    test_config_extremes();

    // idling mixes: none, sender gaps, sink stalls, both
    test_random_traffic(11'd1024, 48'd0, 17'd4096, 0, 0, 150);
    test_random_traffic(11'd16, 48'h1234_5678_9ABC, 17'd64, 61, 0, 150);
    test_random_traffic(11'd1, 48'hFFFF_FFFF_FFFF, 17'd65536, 0, 61, 100);
    test_random_traffic(11'h7FF, 48'({$urandom(), $urandom()}), 17'h1FFFF, 24, 24, 150);
    test_random_traffic(11'd0, 48'({$urandom(), $urandom()}), 17'd0, 61, 0, 40);
    test_random_traffic(11'd8, 48'({$urandom(), $urandom()}), 17'd1, 0, 61, 130);
    test_random_traffic(11'($urandom_range(1, 1024)), 48'({$urandom(), $urandom()}),
                        17'($urandom_range(1, 65536)), 24, 24, 130);

    // drain, then give a stray result time to show up
    wait_idle();
    repeat (1100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #500_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
